// ===== rtl/limit_order_trigger_oco_assert.svh =====
// Assertion macros for the order trigger block.
// Used by the top level only; expects clk and rst in scope.
`ifndef LIMIT_ORDER_TRIGGER_OCO_ASSERT_SVH
`define LIMIT_ORDER_TRIGGER_OCO_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define OCOT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define OCOT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/ocot_pkg.sv =====
// Shared types, codes and helpers for the order trigger block.
// No dependencies.
package ocot_pkg;

  localparam int ORDER_SLOTS  = 16;
  localparam int SYMBOL_COUNT = 16;
  localparam int GROUP_COUNT  = 8;
  localparam int PRICE_BITS   = 32;
  localparam int SLOT_W       = $clog2(ORDER_SLOTS);
  localparam int SYM_W        = $clog2(SYMBOL_COUNT);

  localparam logic [1:0] CMD_PLACE  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OPEN     = 2'd0;
  localparam logic [1:0] ST_FILLED   = 2'd1;
  localparam logic [1:0] ST_CANCELED = 2'd2;

  localparam logic [1:0] EV_OPEN     = 2'd0;
  localparam logic [1:0] EV_FILLED   = 2'd1;
  localparam logic [1:0] EV_CANCELED = 2'd2;
  localparam logic [1:0] EV_TICK     = 2'd3;

  localparam logic KIND_MARKET = 1'b0;
  localparam logic KIND_LIMIT  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_EMIT_OPEN, S_T_RD, S_T_CHK,
    S_G_RD, S_G_CHK, S_F_EMIT, S_C_EMIT, S_FLUSH
  } state_t;

  typedef struct packed {
    logic [3:0]            sym;
    logic                  side;
    logic                  kind;
    logic [PRICE_BITS-1:0] price;
  } ord_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic        okind;
    logic [3:0]  sym;
    logic [31:0] price;
  } ev_t;

  // Buy crosses when market <= limit, sell when market >= limit.
  function automatic logic crosses(input logic side, input logic [PRICE_BITS-1:0] mkt,
                                   input logic [PRICE_BITS-1:0] lim);
    crosses = side ? (mkt >= lim) : (mkt <= lim);
  endfunction

endpackage

// ===== rtl/ocot_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
// Uses no package.
module ocot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/limit_order_trigger_oco.sv =====
// Top level of the order trigger block with one-cancels-other groups.
// Depends on ocot_pkg, ocot_ram and limit_order_trigger_oco_assert.svh.

// One command is worked at a time; in_ready is high only while idle. A place emits
// its open word, a cancel of an open order its cancel word, and a tick its tick word
// and then a scan of every order slot. Each fill adds a fill word, plus a scan of
// every slot for the group when the filled order belongs to a group.
// The order RAM has a single read port with a registered read, so every slot visit
// is an address state then a check state (S_T_RD, S_T_CHK or S_G_RD, S_G_CHK). Results
// leave through a one-word hold stage so the last word of a command can be marked;
// output stalls stretch the work accordingly. No clearing pass after reset.
module limit_order_trigger_oco
  import ocot_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            cmd,
  input  logic [3:0]            order_slot,
  input  logic [3:0]            symbol_id,
  input  logic                  side,
  input  logic                  order_kind,
  input  logic [PRICE_BITS-1:0] price,
  input  logic                  in_group,
  input  logic [2:0]            group_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            event_kind,
  output logic [3:0]            event_slot,
  output logic                  event_order_kind,
  output logic [3:0]            event_symbol,
  output logic [31:0]           event_price,
  output logic                  last_of_run
);

  state_t state, state_next;

  logic [1:0]            c_cmd;
  logic [SLOT_W-1:0]     c_slot;
  logic [3:0]            c_sym;
  logic                  c_side;
  logic                  c_kind;
  logic [PRICE_BITS-1:0] c_price;
  logic [3:0]            c_grp;

  logic [SLOT_W-1:0] j, k, cur;
  logic              cur_kind;
  logic [3:0]        cur_sym;
  logic [3:0]        cur_grp;
  logic              from_tick;

  logic [ORDER_SLOTS-1:0]  used;
  logic [1:0]              status [ORDER_SLOTS];
  logic [3:0]              group  [ORDER_SLOTS];
  logic [SYMBOL_COUNT-1:0] known;

  logic pend_v;
  ev_t  pend;
  ev_t  out_ev;
  logic out_last;

  ord_t                  ord_rd;
  logic [$bits(ord_t)-1:0] ord_rdata;
  logic [PRICE_BITS-1:0] lp_rdata;
  logic                  ord_we, lp_we;
  logic [SLOT_W-1:0]     ord_raddr;

  logic out_free, can_emit, emit;
  ev_t  ev_new;
  logic place_ok, tick_ok, mkt_fill, tick_hit, sib_hit, can_hit, j_last, k_last;

  assign ord_rd   = ord_t'(ord_rdata);
  assign out_free = !out_valid || out_ready;
  assign can_emit = !pend_v || out_free;
  assign place_ok = int'(c_sym) < SYMBOL_COUNT;
  assign tick_ok  = int'(c_sym) < SYMBOL_COUNT;
  assign j_last   = int'(j) == ORDER_SLOTS - 1;
  assign k_last   = int'(k) == ORDER_SLOTS - 1;
  assign mkt_fill = (c_kind == KIND_MARKET) && known[c_sym[SYM_W-1:0]] &&
                    crosses(c_side, lp_rdata, c_price);
  assign tick_hit = used[j] && (status[j] == ST_OPEN) && (ord_rd.kind == KIND_LIMIT) &&
                    (ord_rd.sym == c_sym) && crosses(ord_rd.side, c_price, ord_rd.price);
  assign sib_hit  = (k != cur) && used[k] && (group[k] == cur_grp) &&
                    (status[k] == ST_OPEN);
  assign can_hit  = used[c_slot] && (status[c_slot] == ST_OPEN);

  assign ord_we    = (state == S_DISPATCH) && (c_cmd == CMD_PLACE) && place_ok;
  assign lp_we     = (state == S_DISPATCH) && (c_cmd == CMD_TICK) && tick_ok;
  assign ord_raddr = (state == S_G_RD || state == S_G_CHK) ? k : j;

  ocot_ram #(.DEPTH(ORDER_SLOTS), .WIDTH($bits(ord_t))) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (c_slot),
    .wdata ({c_sym, c_side, c_kind, c_price}),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  ocot_ram #(.DEPTH(SYMBOL_COUNT), .WIDTH(PRICE_BITS)) u_lp_ram (
    .clk   (clk),
    .we    (lp_we),
    .waddr (c_sym[SYM_W-1:0]),
    .wdata (c_price),
    .raddr (c_sym[SYM_W-1:0]),
    .rdata (lp_rdata)
  );

  assign in_ready         = (state == S_IDLE);
  assign event_kind       = out_ev.kind;
  assign event_slot       = out_ev.slot;
  assign event_order_kind = out_ev.okind;
  assign event_symbol     = out_ev.sym;
  assign event_price      = out_ev.price;
  assign last_of_run      = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    ev_new     = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (c_cmd)
          CMD_PLACE:  state_next = place_ok ? S_EMIT_OPEN : S_FLUSH;
          CMD_TICK: begin
            if (!tick_ok) begin
              state_next = S_FLUSH;
            end else if (can_emit) begin
              emit         = 1'b1;
              ev_new.kind  = EV_TICK;
              ev_new.sym   = c_sym;
              ev_new.price = 32'(c_price);
              state_next   = S_T_RD;
            end
          end
          CMD_CANCEL: state_next = S_C_EMIT;
          default:    state_next = S_FLUSH;
        endcase
      end
      S_EMIT_OPEN: begin
        if (can_emit) begin
          emit         = 1'b1;
          ev_new.kind  = EV_OPEN;
          ev_new.slot  = 4'(c_slot);
          ev_new.okind = c_kind;
          ev_new.sym   = c_sym;
          state_next   = mkt_fill ? (c_grp[3] ? S_G_RD : S_F_EMIT) : S_FLUSH;
        end
      end
      S_T_RD: state_next = S_T_CHK;
      S_T_CHK: begin
        if (tick_hit) state_next = group[j][3] ? S_G_RD : S_F_EMIT;
        else          state_next = j_last ? S_FLUSH : S_T_RD;
      end
      S_G_RD: state_next = S_G_CHK;
      S_G_CHK: begin
        if (sib_hit) begin
          if (can_emit) begin
            emit         = 1'b1;
            ev_new.kind  = EV_CANCELED;
            ev_new.slot  = 4'(k);
            ev_new.okind = ord_rd.kind;
            ev_new.sym   = ord_rd.sym;
            state_next   = k_last ? S_F_EMIT : S_G_RD;
          end
        end else begin
          state_next = k_last ? S_F_EMIT : S_G_RD;
        end
      end
      S_F_EMIT: begin
        if (can_emit) begin
          emit         = 1'b1;
          ev_new.kind  = EV_FILLED;
          ev_new.slot  = 4'(cur);
          ev_new.okind = cur_kind;
          ev_new.sym   = cur_sym;
          state_next   = (from_tick && !j_last) ? S_T_RD : S_FLUSH;
        end
      end
      S_C_EMIT: begin
        if (!can_hit) begin
          state_next = S_FLUSH;
        end else if (can_emit) begin
          emit         = 1'b1;
          ev_new.kind  = EV_CANCELED;
          ev_new.slot  = 4'(c_slot);
          ev_new.okind = ord_rd.kind;
          ev_new.sym   = ord_rd.sym;
          state_next   = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_v || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command latch and scan registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      c_cmd   <= cmd;
      c_slot  <= order_slot[SLOT_W-1:0];
      c_sym   <= symbol_id;
      c_side  <= side;
      c_kind  <= order_kind;
      c_price <= price;
      c_grp   <= (in_group && int'(group_id) < GROUP_COUNT) ? {1'b1, group_id} : 4'd0;
      j       <= (cmd == CMD_TICK) ? '0 : order_slot[SLOT_W-1:0];
    end
    if (state == S_EMIT_OPEN && can_emit && mkt_fill) begin
      cur       <= c_slot;
      cur_kind  <= c_kind;
      cur_sym   <= c_sym;
      cur_grp   <= c_grp;
      from_tick <= 1'b0;
      k         <= '0;
    end
    if (state == S_T_CHK) begin
      if (tick_hit) begin
        cur       <= j;
        cur_kind  <= ord_rd.kind;
        cur_sym   <= ord_rd.sym;
        cur_grp   <= group[j];
        from_tick <= 1'b1;
        k         <= '0;
      end else if (!j_last) begin
        j <= j + 1'b1;
      end
    end
    if (state == S_G_CHK && (!sib_hit || can_emit) && !k_last) begin
      k <= k + 1'b1;
    end
    if (state == S_F_EMIT && can_emit && from_tick && !j_last) begin
      j <= j + 1'b1;
    end
    if (emit) begin
      pend <= ev_new;
    end
    if (emit && pend_v) begin
      out_ev   <= pend;
      out_last <= 1'b0;
    end else if (state == S_FLUSH && pend_v && out_free) begin
      out_ev   <= pend;
      out_last <= 1'b1;
    end
  end

  // Slot status, groups and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      known     <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        status[i] <= ST_OPEN;
        group[i]  <= 4'd0;
      end
    end else begin
      if (ord_we) begin
        used[c_slot]   <= 1'b1;
        status[c_slot] <= ST_OPEN;
        group[c_slot]  <= c_grp;
      end
      if (lp_we) begin
        known[c_sym[SYM_W-1:0]] <= 1'b1;
      end
      if (state == S_EMIT_OPEN && can_emit && mkt_fill) begin
        status[c_slot] <= ST_FILLED;
      end
      if (state == S_T_CHK && tick_hit) begin
        status[j] <= ST_FILLED;
      end
      if (state == S_G_CHK && sib_hit && can_emit) begin
        status[k] <= ST_CANCELED;
      end
      if (state == S_C_EMIT && can_hit && can_emit) begin
        status[c_slot] <= ST_CANCELED;
      end
      if (emit) begin
        pend_v <= 1'b1;
      end else if (state == S_FLUSH && pend_v && out_free) begin
        pend_v <= 1'b0;
      end
      // load a word into the output stage, else drop it once taken
      if ((emit && pend_v) || (state == S_FLUSH && pend_v && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`include "limit_order_trigger_oco_assert.svh"

  `OCOT_ASSERT(a_idle_no_pend, (state != S_IDLE) || !pend_v, "held word left at idle")
  `OCOT_ASSERT(a_tick_fields, !(out_valid && event_kind == EV_TICK) || (event_slot == 4'd0 && event_order_kind == 1'b0), "tick word carries slot data")
  `OCOT_ASSERT(a_order_price, !(out_valid && event_kind != EV_TICK) || (event_price == 32'd0), "order word carries a price")
  `OCOT_ASSERT_NEXT(a_flush_done, (state == S_FLUSH) && out_free, state == S_IDLE, "flush did not finish")

endmodule

// ===== tb/sv/limit_order_trigger_oco_checker.sv =====
// Order event checker for the order trigger block: watches both channels,
// keeps its own order book, predicts events and compares. Depends on ocot_pkg.
module limit_order_trigger_oco_checker
  import ocot_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            cmd,
  input  logic [3:0]            order_slot,
  input  logic [3:0]            symbol_id,
  input  logic                  side,
  input  logic                  order_kind,
  input  logic [PRICE_BITS-1:0] price,
  input  logic                  in_group,
  input  logic [2:0]            group_id,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            event_kind,
  input  logic [3:0]            event_slot,
  input  logic                  event_order_kind,
  input  logic [3:0]            event_symbol,
  input  logic [31:0]           event_price,
  input  logic                  last_of_run,
  output int                    errors,
  output int                    pending,
  output int                    events_seen,
  output int                    fills_seen
);

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic        okind;
    logic [3:0]  sym;
    logic [31:0] price;
    logic        last;
  } event_word_t;

  event_word_t events_due[$];

  logic                  book_used [ORDER_SLOTS];
  logic [1:0]            book_status [ORDER_SLOTS];
  logic [3:0]            book_sym [ORDER_SLOTS];
  logic                  book_side [ORDER_SLOTS];
  logic                  book_kind [ORDER_SLOTS];
  logic [PRICE_BITS-1:0] book_price [ORDER_SLOTS];
  logic [3:0]            book_group [ORDER_SLOTS];
  logic [PRICE_BITS-1:0] mkt_price [SYMBOL_COUNT];
  logic                  mkt_known [SYMBOL_COUNT];

  function automatic void queue_event(logic [1:0] k, int s, logic ok, logic [3:0] sy,
                                      logic [31:0] p);
    event_word_t w;
    w.kind = k; w.slot = s[3:0]; w.okind = ok; w.sym = sy; w.price = p; w.last = 1'b0;
    events_due.insert(events_due.size(), w);
  endfunction

  function automatic void fill_if_crossed(int s, logic [PRICE_BITS-1:0] mkt);
    logic hit;
    hit = book_side[s] ? (mkt >= book_price[s]) : (mkt <= book_price[s]);
    if (!hit) return;
    book_status[s] = ST_FILLED;
    if (book_group[s][3]) begin
      for (int j = 0; j < ORDER_SLOTS; j++) begin
        if (j != s && book_used[j] && book_group[j] == book_group[s] &&
            book_status[j] == ST_OPEN) begin
          book_status[j] = ST_CANCELED;
          queue_event(EV_CANCELED, j, book_kind[j], book_sym[j], '0);
        end
      end
    end
    queue_event(EV_FILLED, s, book_kind[s], book_sym[s], '0);
  endfunction

  function automatic void predict_events();
    int base;
    int s;
    base = events_due.size();
    s = int'(order_slot);
    case (cmd)
      CMD_PLACE: begin
        book_used[s] = 1'b1;
        book_status[s] = ST_OPEN;
        book_sym[s] = symbol_id;
        book_side[s] = side;
        book_kind[s] = order_kind;
        book_price[s] = price;
        book_group[s] = in_group ? {1'b1, group_id} : 4'd0;
        queue_event(EV_OPEN, s, order_kind, symbol_id, '0);
        if (order_kind == KIND_MARKET && mkt_known[symbol_id])
          fill_if_crossed(s, mkt_price[symbol_id]);
      end
      CMD_TICK: begin
        queue_event(EV_TICK, 0, 1'b0, symbol_id, price);
        mkt_price[symbol_id] = price;
        mkt_known[symbol_id] = 1'b1;
        for (int j = 0; j < ORDER_SLOTS; j++)
          if (book_used[j] && book_sym[j] == symbol_id && book_status[j] == ST_OPEN &&
              book_kind[j] == KIND_LIMIT)
            fill_if_crossed(j, price);
      end
      CMD_CANCEL: begin
        if (book_used[s] && book_status[s] == ST_OPEN) begin
          book_status[s] = ST_CANCELED;
          queue_event(EV_CANCELED, s, book_kind[s], book_sym[s], '0);
        end
      end
      default: ;
    endcase
    if (events_due.size() > base) events_due[events_due.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    event_word_t w;
    if (rst) begin
      events_due.delete();
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        book_used[i] = 1'b0; book_status[i] = ST_OPEN; book_group[i] = 4'd0;
      end
      for (int i = 0; i < SYMBOL_COUNT; i++) mkt_known[i] = 1'b0;
      errors <= 0; events_seen <= 0; fills_seen <= 0;
    end else begin
      // check output first: an input taken this edge cannot produce a word yet
      if (out_valid && out_ready) begin
        events_seen <= events_seen + 1;
        if (event_kind == EV_FILLED) fills_seen <= fills_seen + 1;
        if (events_due.size() == 0) begin
          $error("unexpected event word kind=%0d slot=%0d", event_kind, event_slot);
          errors <= errors + 1;
        end else begin
          w = events_due.pop_front();
          if (event_kind !== w.kind || event_slot !== w.slot ||
              event_order_kind !== w.okind || event_symbol !== w.sym ||
              event_price !== w.price || last_of_run !== w.last) begin
            errors <= errors + 1;
            if (event_kind !== w.kind)
              $error("event_kind expected %0d got %0d", w.kind, event_kind);
            if (event_slot !== w.slot)
              $error("event_slot expected %0d got %0d", w.slot, event_slot);
            if (event_order_kind !== w.okind)
              $error("event_order_kind expected %0d got %0d", w.okind, event_order_kind);
            if (event_symbol !== w.sym)
              $error("event_symbol expected %0d got %0d", w.sym, event_symbol);
            if (event_price !== w.price)
              $error("event_price expected %0d got %0d", w.price, event_price);
            if (last_of_run !== w.last)
              $error("last_of_run expected %0d got %0d", w.last, last_of_run);
          end
        end
      end
      if (in_valid && in_ready) predict_events();
    end
    pending <= events_due.size();
  end

endmodule

// ===== tb/sv/limit_order_trigger_oco_tb.sv =====
// Testbench top for the order trigger block: drives commands, stalls the event
// side, and reports. Depends on ocot_pkg, the block and the checker module.
module limit_order_trigger_oco_tb;
  import ocot_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            cmd;
  logic [3:0]            order_slot;
  logic [3:0]            symbol_id;
  logic                  side;
  logic                  order_kind;
  logic [PRICE_BITS-1:0] price;
  logic                  in_group;
  logic [2:0]            group_id;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            event_kind;
  logic [3:0]            event_slot;
  logic                  event_order_kind;
  logic [3:0]            event_symbol;
  logic [31:0]           event_price;
  logic                  last_of_run;
  int                    errors;
  int                    pending;
  int                    events_seen;
  int                    fills_seen;
  int                    cycles;
  bit                    calm_phase;
  bit                    hold_off_req;
  int                    words_sent;

  limit_order_trigger_oco uut (.*);
  limit_order_trigger_oco_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("limit_order_trigger_oco test failed");
      $finish;
    end
  end

  // event side: random stall bursts, one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (1) begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // valid stays up into the next word unless an idle burst comes first
  task automatic send_word(logic [1:0] c, logic [3:0] sl, logic [3:0] sy, logic sd,
                           logic k, logic [31:0] p, logic g, logic [2:0] gid);
    int n;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1; cmd <= c; order_slot <= sl; symbol_id <= sy; side <= sd;
    order_kind <= k; price <= p; in_group <= g; group_id <= gid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random();
    logic [1:0] c;
    logic [31:0] p;
    logic [3:0] sy;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) c = CMD_PLACE;
    else if (r < 80) c = CMD_TICK;
    else if (r < 97) c = CMD_CANCEL;
    else c = CMD_UNUSED;
    // narrow prices around 100 make crossings common; rest full range
    p = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(90, 110));
    sy = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                     : 4'($urandom_range(0, 2));
    send_word(c, 4'($urandom_range(0, 15)), sy, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), p, 1'($urandom_range(0, 1)),
              3'($urandom_range(0, 7)));
  endtask

  initial begin
    calm_phase = 0; hold_off_req = 0; words_sent = 0;
    rst <= 1'b1; in_valid <= 1'b0; cmd <= CMD_PLACE; order_slot <= '0; symbol_id <= '0;
    side <= 1'b0; order_kind <= KIND_MARKET; price <= '0; in_group <= 1'b0;
    group_id <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // market order with no known price stays open; cancel it twice and slot 9
    send_word(CMD_PLACE, 4'd0, 4'd0, 1'b0, KIND_MARKET, 32'd100, 1'b0, 3'd0);
    send_word(CMD_CANCEL, 4'd0, 4'd0, 1'b0, 1'b0, 32'd0, 1'b0, 3'd0);
    send_word(CMD_CANCEL, 4'd0, 4'd0, 1'b0, 1'b0, 32'd0, 1'b0, 3'd0);
    send_word(CMD_CANCEL, 4'd9, 4'd0, 1'b0, 1'b0, 32'd0, 1'b0, 3'd0);
    // one-cancels-other group of three limit orders, then two crossing ticks
    send_word(CMD_PLACE, 4'd1, 4'd15, 1'b0, KIND_LIMIT, 32'd100, 1'b1, 3'd7);
    send_word(CMD_PLACE, 4'd2, 4'd15, 1'b1, KIND_LIMIT, 32'd200, 1'b1, 3'd7);
    send_word(CMD_PLACE, 4'd15, 4'd3, 1'b1, KIND_LIMIT, 32'hFFFF_FFFF, 1'b1, 3'd7);
    send_word(CMD_PLACE, 4'd3, 4'd15, 1'b1, KIND_LIMIT, 32'd0, 1'b0, 3'd0);
    send_word(CMD_TICK, 4'd0, 4'd15, 1'b0, 1'b0, 32'd150, 1'b0, 3'd0);
    send_word(CMD_TICK, 4'd0, 4'd3, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 3'd0);
    // market orders against a known price, both sides, crossing and not
    send_word(CMD_PLACE, 4'd4, 4'd15, 1'b0, KIND_MARKET, 32'd150, 1'b0, 3'd0);
    send_word(CMD_PLACE, 4'd5, 4'd15, 1'b1, KIND_MARKET, 32'd151, 1'b0, 3'd0);
    send_word(CMD_PLACE, 4'd5, 4'd15, 1'b1, KIND_MARKET, 32'd0, 1'b1, 3'd2);
    send_word(CMD_TICK, 4'd0, 4'd0, 1'b0, 1'b0, 32'd0, 1'b0, 3'd0);
    send_word(CMD_UNUSED, 4'd0, 4'd0, 1'b0, 1'b0, 32'd0, 1'b0, 3'd0);
    // fill all sixteen slots on one symbol, then one tick fills them all
    for (int i = 0; i < 16; i++)
      send_word(CMD_PLACE, i[3:0], 4'd1, 1'b0, KIND_LIMIT, 32'd50, 1'b0, 3'd0);
    send_word(CMD_TICK, 4'd0, 4'd1, 1'b0, 1'b0, 32'd10, 1'b0, 3'd0);
    drain();
    // long event stall while commands keep coming
    hold_off_req <= 1'b1;
    for (int i = 0; i < 20; i++) send_random();
    drain();
    for (int i = 0; i < 480; i++) begin
      if (i == 420) calm_phase = 1;
      send_random();
    end
    drain();
    repeat (200) @(posedge clk);
    $display("ran %0d commands; %0d events checked, %0d fills", words_sent,
             events_seen, fills_seen);
    if (errors == 0 && pending == 0) begin
      $display("limit_order_trigger_oco test passed");
    end else begin
      $display("limit_order_trigger_oco test failed");
    end
    $finish;
  end

endmodule

// ===== limit_order_trigger_oco.f =====
+incdir+rtl
rtl/ocot_pkg.sv
rtl/ocot_ram.sv
rtl/limit_order_trigger_oco.sv
tb/sv/limit_order_trigger_oco_checker.sv
tb/sv/limit_order_trigger_oco_tb.sv
